[hw/rtl/svd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Standardized vector distance package
// Shared widths, codes and the word types passed between front and back.
// ----------------------------------------------------------------------------
package svd_pkg;

   localparam int DataWidth  = 32;
   localparam int FracBits   = 16;
   localparam int MaxLength  = 1024;
   localparam int CountWidth = 11;
   localparam int AccWidth   = 64;
   localparam int CsrWidth   = 2;
   localparam int CsrIdxWidth = 1;
   localparam int DivWidth   = DataWidth + 1 + FracBits;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      MODE_RMS  = 2'd0,
      MODE_MEAN = 2'd1,
      MODE_MAX  = 2'd2,
      MODE_MAXB = 2'd3
   } mode_type;

   localparam logic [CsrIdxWidth-1:0] CSR_METRIC_MODE = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CSR_INVERT_MEAN = 1'b1;

   typedef struct packed {
      logic [DataWidth:0]   magnitude;
      logic [DataWidth-1:0] divisor;
      logic                 zero_dev;
      logic                 counted;
      logic                 last;
      mode_type             mode;
   } work_type;

endpackage : svd_pkg
`default_nettype wire

[hw/rtl/svd_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Standardized vector distance front end
// Accepts words, forms |m - x|, classifies the element and queues the work.
// ----------------------------------------------------------------------------
module svd_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [svd_pkg::DataWidth-1:0] req_mean_value,
   input  wire logic signed [svd_pkg::DataWidth-1:0] req_stdev_value,
   input  wire logic signed [svd_pkg::DataWidth-1:0] req_sample_value,
   input  wire logic                                req_element_valid,
   input  wire logic                                req_last_element,
   input  wire svd_pkg::mode_type                   mode,
   input  wire logic                                invert,
   output logic                                     work_valid,
   input  wire logic                                work_ready,
   output svd_pkg::work_type                        work_word
);

   localparam int DW = svd_pkg::DataWidth;
   localparam int CW = svd_pkg::CountWidth;

   svd_pkg::work_type queue_ff [svd_pkg::QueueDepth];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic [CW-1:0]     count_ff, count_in;
   logic signed [DW+1:0] m_ext, diff;
   logic              push, pop, counted;
   svd_pkg::work_type entry;

   assign req_ready  = (fill_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign work_valid = (fill_ff != 2'd0);
   assign pop        = work_valid && work_ready;
   assign work_word  = queue_ff[rd_ptr_ff];

   always_comb begin
      m_ext = {{2{req_mean_value[DW-1]}}, req_mean_value};
      if (invert) begin
         m_ext = -m_ext;
      end
      diff = m_ext - {{2{req_sample_value[DW-1]}}, req_sample_value};
      counted = req_element_valid && (count_ff < CW'(svd_pkg::MaxLength));
      entry.magnitude = diff[DW+1] ? (DW+1)'(0) - diff[DW:0] : diff[DW:0];
      entry.divisor   = req_stdev_value;
      entry.zero_dev  = req_stdev_value[DW-1] || (req_stdev_value == '0);
      entry.counted   = counted;
      entry.last      = req_last_element;
      entry.mode      = mode;
      count_in  = count_ff;
      if (push) begin
         if (req_last_element) begin
            count_in = '0;
         end else if (counted) begin
            count_in = count_ff + CW'(1);
         end
      end
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
      end
   end

endmodule : svd_front
`default_nettype wire

[hw/rtl/svd_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Standardized vector distance back end
// Divides one bit a cycle, accumulates, and on the last word finishes with a
// division by the count (RMS and mean) and a bit-pair square root (RMS only).
// ----------------------------------------------------------------------------
module svd_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         work_valid,
   output logic                              work_ready,
   input  wire svd_pkg::work_type            work_word,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [svd_pkg::DataWidth-1:0]     rsp_distance,
   output logic [svd_pkg::CountWidth-1:0]    rsp_used_count
);

   localparam int DW = svd_pkg::DataWidth;
   localparam int AW = svd_pkg::AccWidth;
   localparam int CW = svd_pkg::CountWidth;
   localparam int QW = svd_pkg::DivWidth;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_ACC, ST_FDIV, ST_SQRT, ST_SQ, ST_OUT
   } state_type;

   state_type         state_ff;
   svd_pkg::work_type word_ff;
   logic [QW-1:0]     quot_ff;
   logic [AW:0]       rem_ff;
   logic [6:0]        step_ff;
   logic [AW-1:0]     acc_ff, val_ff, root_ff;
   logic [CW-1:0]     count_ff;
   logic [2*DW-1:0]   sq_ff;
   logic [DW-1:0]     ad;
   logic [AW:0]       trial;
   logic [AW+1:0]     sum;
   logic [AW-1:0]     acc_new, bit_v, sel, res;
   logic [CW-1:0]     count_new;

   assign work_ready = (state_ff == ST_IDLE);

   always_comb begin
      ad = (quot_ff[QW-1:DW] != '0) ? '1 : quot_ff[DW-1:0];
      if (word_ff.zero_dev) begin
         ad = '0;
      end
      trial    = {rem_ff[AW-1:0], 1'b0};
      acc_new   = acc_ff;
      count_new = count_ff;
      if (word_ff.counted) begin
         count_new = count_ff + CW'(1);
         case (word_ff.mode)
            svd_pkg::MODE_RMS: begin
               sum = {2'b0, acc_ff} + {2'b0, sq_ff};
               acc_new = sum[AW] ? '1 : sum[AW-1:0];
            end
            svd_pkg::MODE_MEAN: begin
               sum = {2'b0, acc_ff} + (AW+2)'(ad);
               acc_new = sum[AW] ? '1 : sum[AW-1:0];
            end
            default: begin
               sum = '0;
               if (AW'(ad) > acc_ff) begin
                  acc_new = AW'(ad);
               end
            end
         endcase
      end else begin
         sum = '0;
      end
      bit_v = AW'(1) << {step_ff[5:0], 1'b0};
      sel   = (word_ff.mode == svd_pkg::MODE_MEAN && rsp_used_count != '0) ? val_ff
                                                                         : root_ff;
      res   = (sel > AW'({DW{1'b1}})) ? AW'({DW{1'b1}}) : sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
         acc_ff    <= '0;
         count_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (work_valid) begin
                  word_ff  <= work_word;
                  quot_ff  <= QW'(work_word.magnitude) << svd_pkg::FracBits;
                  rem_ff   <= '0;
                  step_ff  <= 7'(QW);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if ({trial[AW:1], quot_ff[QW-1]} >= (AW+1)'(word_ff.divisor)) begin
                  rem_ff  <= {trial[AW:1], quot_ff[QW-1]} - (AW+1)'(word_ff.divisor);
                  quot_ff <= {quot_ff[QW-2:0], 1'b1};
               end else begin
                  rem_ff  <= {trial[AW:1], quot_ff[QW-1]};
                  quot_ff <= {quot_ff[QW-2:0], 1'b0};
               end
               step_ff <= step_ff - 7'd1;
               if (step_ff == 7'd1 || word_ff.zero_dev) begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               sq_ff    <= ad * ad;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (word_ff.last) begin
                  acc_ff   <= '0;
                  count_ff <= '0;
                  rsp_used_count <= count_new;
                  val_ff  <= acc_new;
                  rem_ff  <= '0;
                  step_ff <= 7'(AW);
                  if (count_new == '0) begin
                     root_ff  <= '0;
                     state_ff <= ST_OUT;
                  end else if (word_ff.mode == svd_pkg::MODE_RMS ||
                               word_ff.mode == svd_pkg::MODE_MEAN) begin
                     root_ff  <= '0;
                     state_ff <= ST_FDIV;
                  end else begin
                     root_ff  <= acc_new;
                     state_ff <= ST_OUT;
                  end
               end else begin
                  acc_ff   <= acc_new;
                  count_ff <= count_new;
                  state_ff <= ST_IDLE;
               end
            end
            ST_FDIV: begin
               if ({rem_ff[AW-1:0], val_ff[AW-1]} >= (AW+1)'(rsp_used_count)) begin
                  rem_ff <= {rem_ff[AW-1:0], val_ff[AW-1]} - (AW+1)'(rsp_used_count);
                  val_ff <= {val_ff[AW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[AW-1:0], val_ff[AW-1]};
                  val_ff <= {val_ff[AW-2:0], 1'b0};
               end
               if (step_ff == 7'd1) begin
                  step_ff <= 7'(AW/2 - 1);
                  if (word_ff.mode == svd_pkg::MODE_RMS) begin
                     state_ff <= ST_SQRT;
                  end else begin
                     state_ff <= ST_OUT;
                  end
               end else begin
                  step_ff <= step_ff - 7'd1;
               end
            end
            ST_SQRT: begin
               if (val_ff >= (root_ff | bit_v)) begin
                  val_ff  <= val_ff - (root_ff | bit_v);
                  root_ff <= (root_ff >> 1) | bit_v;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               step_ff <= step_ff - 7'd1;
               if (step_ff == 7'd0) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid) begin
                  rsp_valid    <= 1'b1;
                  rsp_distance <= res[DW-1:0];
               end else if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule : svd_back
`default_nettype wire

[hw/rtl/standardized_vector_distance.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Standardized vector distance
// RMS, mean absolute or maximum of standardized element deviations.
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_ready | mean, stdev, sample, valid, last
// rsp     | out | rsp_valid/rsp_ready | distance, used_count
// csr     | in  | csr_write           | csr_index, csr_data
// Each word is loaded, run through the bit-serial divider (cut short when the
// deviation is not positive), squared and accumulated. The last adds the
// division by the count (RMS and mean), the root (RMS only) and the
// presentation and hand-over of the result.
// A two-entry queue lets the front take words while the back is busy.
// Reset is synchronous; the result holds until rsp_ready.
// ----------------------------------------------------------------------------
module standardized_vector_distance (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [svd_pkg::DataWidth-1:0] req_mean_value,
   input  wire logic signed [svd_pkg::DataWidth-1:0] req_stdev_value,
   input  wire logic signed [svd_pkg::DataWidth-1:0] req_sample_value,
   input  wire logic                                req_element_valid,
   input  wire logic                                req_last_element,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [svd_pkg::DataWidth-1:0]            rsp_distance,
   output logic [svd_pkg::CountWidth-1:0]           rsp_used_count,
   input  wire logic                                csr_write,
   input  wire logic [svd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire logic [svd_pkg::CsrWidth-1:0]        csr_data
);

   svd_pkg::mode_type mode_ff;
   logic              invert_ff;
   logic              work_valid, work_ready;
   svd_pkg::work_type work_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= svd_pkg::MODE_RMS;
         invert_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            svd_pkg::CSR_METRIC_MODE: mode_ff   <= svd_pkg::mode_type'(csr_data);
            svd_pkg::CSR_INVERT_MEAN: invert_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   svd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mean_value, .req_stdev_value,
      .req_sample_value, .req_element_valid, .req_last_element,
      .mode(mode_ff), .invert(invert_ff),
      .work_valid, .work_ready, .work_word
   );

   svd_back u_back (
      .clock, .reset, .work_valid, .work_ready, .work_word,
      .rsp_valid, .rsp_ready, .rsp_distance, .rsp_used_count
   );

endmodule : standardized_vector_distance
`default_nettype wire

[hw/rtl/svd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Standardized vector distance checker
// Port-level properties of the response channel.
// ----------------------------------------------------------------------------
module svd_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [svd_pkg::DataWidth-1:0] rsp_distance,
   input wire logic [svd_pkg::CountWidth-1:0] rsp_used_count
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("result word dropped while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_count <= svd_pkg::CountWidth'(svd_pkg::MaxLength))
      else $error("count beyond maximum length");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_used_count == '0 |-> rsp_distance == '0)
      else $error("nonzero distance with no elements");

   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("back-to-back result words");

endmodule : svd_checker

bind standardized_vector_distance svd_checker u_svd_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_distance, .rsp_used_count
);
`default_nettype wire

[dv/standardized_vector_distance_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Standardized vector distance testbench
// Drives vectors of mean, deviation and sample words through the request
// channel under random idling and stalls. Predicts the distance and the
// element count of each vector and checks every response in order.
// ----------------------------------------------------------------------------
module standardized_vector_distance_tb;

   typedef struct {
      logic [31:0] mean_value;
      logic [31:0] stdev_value;
      logic [31:0] sample_value;
      logic        element_valid;
      logic        last_element;
   } element_type;

   typedef struct {
      logic [31:0] distance;
      logic [10:0] used_count;
   } distance_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_mean_value = '0;
   logic signed [31:0] req_stdev_value = '0;
   logic signed [31:0] req_sample_value = '0;
   logic req_element_valid = 1'b0;
   logic req_last_element = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [31:0] rsp_distance;
   logic [10:0] rsp_used_count;
   logic csr_write = 1'b0;
   logic [svd_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [svd_pkg::CsrWidth-1:0] csr_data = '0;

   element_type        pending_words[$];
   distance_type       expected_distances[$];
   svd_pkg::mode_type  model_mode;
   logic               model_invert;
   logic [63:0]        model_sum;
   logic [10:0]        model_count;
   logic               req_taken = 1'b0;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_off_cycles;
   int  quiet_cycles;
   int  failures;

   standardized_vector_distance i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] standardized_magnitude(input element_type e);
      logic signed [63:0] m;
      logic signed [63:0] diff;
      logic [63:0] q;
      if ($signed(e.stdev_value) <= 0) return 0;
      m = $signed(e.mean_value);
      if (model_invert) m = -m;
      diff = m - $signed(e.sample_value);
      if (diff < 0) diff = -diff;
      q = (64'(diff) << svd_pkg::FracBits) / 64'($signed(e.stdev_value));
      return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
   endfunction

   task automatic predict_distance(input element_type e);
      logic [63:0] ad;
      logic [63:0] sq;
      logic [63:0] res;
      distance_type d;
      if (e.element_valid && model_count < svd_pkg::MaxLength) begin
         ad = standardized_magnitude(e);
         if (model_mode == svd_pkg::MODE_RMS) begin
            sq = ad * ad;
            model_sum = (model_sum > ~64'd0 - sq) ? ~64'd0 : model_sum + sq;
         end else if (model_mode == svd_pkg::MODE_MEAN) begin
            model_sum = (model_sum > ~64'd0 - ad) ? ~64'd0 : model_sum + ad;
         end else if (ad > model_sum) begin
            model_sum = ad;
         end
         model_count++;
      end
      if (e.last_element) begin
         res = 0;
         if (model_count != 0) begin
            if (model_mode == svd_pkg::MODE_RMS) res = root_floor(model_sum / model_count);
            else if (model_mode == svd_pkg::MODE_MEAN) res = model_sum / model_count;
            else res = model_sum;
            if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
         end
         d.distance = res[31:0];
         d.used_count = model_count;
         expected_distances.push_back(d);
         model_sum = 0;
         model_count = 0;
      end
   endtask

   always @(negedge clock) begin
      element_type e;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               e = pending_words[0];
               req_valid <= 1'b1;
               req_mean_value <= e.mean_value;
               req_stdev_value <= e.stdev_value;
               req_sample_value <= e.sample_value;
               req_element_valid <= e.element_valid;
               req_last_element <= e.last_element;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      distance_type d;
      if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_distance('{req_mean_value, req_stdev_value, req_sample_value,
                               req_element_valid, req_last_element});
            void'(pending_words.pop_front());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_distances.size() == 0) begin
               $display("%0t: unexpected word expected none actual distance %h count %0d",
                        $time, rsp_distance, rsp_used_count);
               failures++;
            end else begin
               d = expected_distances.pop_front();
               if (rsp_distance !== d.distance) begin
                  $display("%0t: distance expected %h actual %h", $time,
                           d.distance, rsp_distance);
                  failures++;
               end
               if (rsp_used_count !== d.used_count) begin
                  $display("%0t: used_count expected %0d actual %0d", $time,
                           d.used_count, rsp_used_count);
                  failures++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic logic [31:0] random_field();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(3);
         3: return $urandom_range(32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_word(input logic [31:0] m, input logic [31:0] s,
                             input logic [31:0] x, input logic v, input logic l);
      element_type e;
      e.mean_value = m;
      e.stdev_value = s;
      e.sample_value = x;
      e.element_valid = v;
      e.last_element = l;
      pending_words.push_back(e);
   endtask

   task automatic queue_vector(input int len);
      logic [31:0] s;
      for (int i = 0; i < len; i++) begin
         s = ($urandom_range(9) == 0) ? random_field() :
             $urandom_range(32'h0002_0000, 32'h0000_0100);
         queue_word(random_field(), s, random_field(), $urandom_range(9) != 0,
                    i == len - 1);
      end
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || expected_distances.size() > 0 || req_valid)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(input logic [svd_pkg::CsrIdxWidth-1:0] idx,
                            input logic [1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == svd_pkg::CSR_METRIC_MODE) model_mode = svd_pkg::mode_type'(value);
      else model_invert = value[0];
   endtask

   task automatic random_phase(input int words);
      int n;
      n = 0;
      while (n < words) begin
         if ($urandom_range(19) == 0) begin
            queue_word(random_field(), random_field(), random_field(),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
            n++;
         end else begin
            automatic int len = $urandom_range(8, 1);
            queue_vector(len);
            n += len;
         end
      end
   endtask

   initial begin
      svd_pkg::mode_type modes[4];
      modes = '{svd_pkg::MODE_RMS, svd_pkg::MODE_MEAN, svd_pkg::MODE_MAX,
                svd_pkg::MODE_MAXB};
      model_mode = svd_pkg::MODE_RMS;
      model_invert = 1'b0;
      model_sum = 0;
      model_count = 0;
      failures = 0;
      quiet_cycles = 0;
      hold_off_cycles = 0;
      send_idle_pct = 8;
      recv_idle_pct = 57;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_word(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1, 0);
      queue_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
      queue_word(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1, 0);
      queue_word(32'h0001_0000, 32'h8000_0000, 32'h0000_0000, 1, 0);
      queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1);
      queue_word(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 0, 1);
      queue_word(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 1, 1);
      drain();
      for (int k = 0; k < 4; k++) begin
         write_csr(svd_pkg::CSR_METRIC_MODE, modes[k]);
         write_csr(svd_pkg::CSR_INVERT_MEAN, 2'(k[0]));
         queue_word(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 1, 0);
         queue_word(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1, 0);
         queue_word(32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000, 1, 1);
         drain();
      end
      write_csr(svd_pkg::CSR_METRIC_MODE, svd_pkg::MODE_MEAN);
      for (int i = 0; i < 300; i++)
         queue_word(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1, i == 299);
      drain();

      for (int p = 0; p < 3; p++) begin
         if (p == 1) begin
            send_idle_pct = 57;
            recv_idle_pct = 8;
         end else if (p == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int k = 0; k < 4; k++) begin
            write_csr(svd_pkg::CSR_METRIC_MODE, modes[(k + p) % 4]);
            write_csr(svd_pkg::CSR_INVERT_MEAN, 2'($urandom_range(1)));
            if (k == 1) hold_off_cycles = 2000;
            random_phase(39);
            drain();
         end
      end

      if (failures == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
